// File: src/ahob_pkg.sv
// ahob_pkg: shared widths, codes, controller/datapath command types and the sine table
// for the additive harmonic oscillator bank. No dependencies; every other file uses it.

package ahob_pkg;

    // bank size and field widths
    localparam int NUM_HARMONICS = 16;
    localparam int HARM_W        = 4;
    localparam int FUNC_W        = 2;
    localparam int ENV_W         = 16;
    localparam int GAIN_W        = 16;
    localparam int PHASE_W       = 32;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_W        = 15;

    // item codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTE_ON = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GAIN    = 2'd2;

    // running harmonic step: up to NUM_HARMONICS times a 32-bit step
    localparam int RUN_W  = PHASE_W + HARM_W + 1;
    // audible gain sum
    localparam int SUM_W  = GAIN_W + HARM_W + 1;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(32768);
    localparam logic [GAIN_W-1:0] GAIN0_RESET = GAIN_W'(32768);

    // sine table: quarter wave with both end points
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
    localparam int SINE_QTR   = SINE_DEPTH / 4;
    localparam int SINE_K_W   = $clog2(SINE_QTR + 1);
    localparam int SINE_MAG_W = 15;

    // datapath products and accumulator
    localparam int EG_W   = ENV_W + GAIN_W;
    localparam int PROD_W = EG_W + SINE_MAG_W;
    localparam int ACC_W  = PROD_W + HARM_W + 2;
    localparam int DIVD_W = ACC_W - FRAC_W;
    localparam int QUOT_W = 16;
    localparam int CNT_W  = $clog2(QUOT_W);
    localparam int DRAIN_CYCLES = 2;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
    localparam logic [QUOT_W-1:0]   POS_LIMIT  = 16'h7FFF;
    localparam logic [QUOT_W-1:0]   NEG_LIMIT  = 16'h8000;

    localparam longint Q30_ONE = 64'sd1073741824;

    typedef logic [SINE_MAG_W-1:0] sine_rom_t [0:SINE_QTR];

    // quarter-wave sine in Q15, odd degree-9 polynomial in Q30, truncating divides
    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    t;
        longint    t2;
        longint    acc;
        longint    v;
        for (int k = 0; k <= SINE_QTR; k++)
        begin
            t   = longint'(k) * (Q30_ONE / SINE_QTR);
            t2  = (t * t) / Q30_ONE;
            acc = 64'sd172272;
            acc = -64'sd5026994 + (acc * t2) / Q30_ONE;
            acc = 64'sd85569306 + (acc * t2) / Q30_ONE;
            acc = -64'sd693598668 + (acc * t2) / Q30_ONE;
            acc = 64'sd1686629713 + (acc * t2) / Q30_ONE;
            v   = (acc * t) / Q30_ONE;
            if (v < 0)
            begin
                v = 0;
            end
            v = (v + 16384) / 32768;
            if (v > 32767)
            begin
                v = 32767;
            end
            rom[k] = SINE_MAG_W'(v);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_TICK,
        ST_DRAIN,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic              load_step;
        logic              load_gain;
        logic              start_tick;
        logic              sum_clear;
        logic              sum_issue;
        logic              tick_issue;
        logic [HARM_W-1:0] harm;
        logic              div_init;
        logic              div_step;
        logic              out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// File: src/ahob_cmd_if.sv
// ahob_cmd_if: input item channel of the oscillator bank, valid/ready with payload
// depends on ahob_pkg for field widths

interface ahob_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ahob_pkg::FUNC_W-1:0]         func;
    logic [ahob_pkg::ENV_W-1:0]          envelope;
    logic [ahob_pkg::PHASE_W-1:0]        note_step;
    logic [ahob_pkg::HARM_W-1:0]         harmonic_index;
    logic [ahob_pkg::GAIN_W-1:0]         gain_value;

    modport source (
        output valid, func, envelope, note_step, harmonic_index, gain_value,
        input  ready
    );

    modport sink (
        input  valid, func, envelope, note_step, harmonic_index, gain_value,
        output ready
    );
endinterface

// File: src/ahob_res_if.sv
// ahob_res_if: result channel of the oscillator bank, valid/ready with sample payload
// depends on ahob_pkg for field widths

interface ahob_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [ahob_pkg::SAMPLE_W-1:0] sample;
    logic                                clipped;

    modport source (
        output valid, sample, clipped,
        input  ready
    );

    modport sink (
        input  valid, sample, clipped,
        output ready
    );
endinterface

// File: src/ahob_ctrl.sv
// ahob_ctrl: controller state machine of the oscillator bank; sequences the gain-sum
// pass, the per-harmonic tick pass, the divider and the result load. Uses ahob_pkg.

module ahob_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [ahob_pkg::FUNC_W-1:0]  in_func,
    output logic                         in_ready,
    output ahob_pkg::dp_cmd_t            dp_cmd,
    input  ahob_pkg::dp_status_t         dp_stat
);

    ahob_pkg::ctrl_state_t            state_reg;
    ahob_pkg::ctrl_state_t            state_next;
    logic [ahob_pkg::HARM_W-1:0]      harm_reg;
    logic [ahob_pkg::HARM_W-1:0]      harm_next;
    logic [ahob_pkg::CNT_W-1:0]       cnt_reg;
    logic [ahob_pkg::CNT_W-1:0]       cnt_next;
    logic                             harm_last;

    assign harm_last = (harm_reg == ahob_pkg::HARM_W'(ahob_pkg::NUM_HARMONICS - 1));

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ahob_pkg::ST_IDLE;
            harm_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            harm_reg  <= harm_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        harm_next  = harm_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ahob_pkg::ST_IDLE:
            begin
                harm_next = '0;
                cnt_next  = '0;
                if (in_valid)
                begin
                    case (in_func)
                        ahob_pkg::FUNC_TICK:    state_next = ahob_pkg::ST_TICK;
                        ahob_pkg::FUNC_NOTE_ON: state_next = ahob_pkg::ST_SUM;
                        ahob_pkg::FUNC_GAIN:    state_next = ahob_pkg::ST_SUM;
                        default:                state_next = ahob_pkg::ST_IDLE;
                    endcase
                end
            end
            ahob_pkg::ST_SUM:
            begin
                harm_next = harm_reg + 1'b1;
                if (harm_last)
                begin
                    state_next = ahob_pkg::ST_IDLE;
                end
            end
            ahob_pkg::ST_TICK:
            begin
                harm_next = harm_reg + 1'b1;
                if (harm_last)
                begin
                    state_next = ahob_pkg::ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ahob_pkg::ST_DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ahob_pkg::CNT_W'(ahob_pkg::DRAIN_CYCLES - 1))
                begin
                    state_next = ahob_pkg::ST_DIV_INIT;
                end
            end
            ahob_pkg::ST_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = ahob_pkg::ST_DIV;
            end
            ahob_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ahob_pkg::CNT_W'(ahob_pkg::QUOT_W - 1))
                begin
                    state_next = ahob_pkg::ST_FINISH;
                end
            end
            ahob_pkg::ST_FINISH:
            begin
                if (dp_stat.out_free)
                begin
                    state_next = ahob_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ahob_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready = 1'b0;
        dp_cmd   = '0;
        dp_cmd.harm = harm_reg;
        case (state_reg)
            ahob_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dp_cmd.load_step  = (in_func == ahob_pkg::FUNC_NOTE_ON);
                    dp_cmd.load_gain  = (in_func == ahob_pkg::FUNC_GAIN);
                    dp_cmd.sum_clear  = (in_func == ahob_pkg::FUNC_NOTE_ON) ||
                                        (in_func == ahob_pkg::FUNC_GAIN);
                    dp_cmd.start_tick = (in_func == ahob_pkg::FUNC_TICK);
                end
            end
            ahob_pkg::ST_SUM:      dp_cmd.sum_issue  = 1'b1;
            ahob_pkg::ST_TICK:     dp_cmd.tick_issue = 1'b1;
            ahob_pkg::ST_DRAIN:    dp_cmd.harm       = harm_reg;
            ahob_pkg::ST_DIV_INIT: dp_cmd.div_init   = 1'b1;
            ahob_pkg::ST_DIV:      dp_cmd.div_step   = 1'b1;
            ahob_pkg::ST_FINISH:   dp_cmd.out_load   = dp_stat.out_free;
            default:               dp_cmd.harm       = harm_reg;
        endcase
    end

endmodule

// File: src/ahob_datapath.sv
// ahob_datapath: phase accumulators, gain store, sine lookup, multiply-accumulate pipe,
// restoring divider and result register. Driven by ahob_ctrl; uses ahob_pkg.

module ahob_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ahob_pkg::dp_cmd_t                     dp_cmd,
    output ahob_pkg::dp_status_t                  dp_stat,
    input  logic [ahob_pkg::ENV_W-1:0]            envelope,
    input  logic [ahob_pkg::PHASE_W-1:0]          note_step,
    input  logic [ahob_pkg::HARM_W-1:0]           harmonic_index,
    input  logic [ahob_pkg::GAIN_W-1:0]           gain_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ahob_pkg::SAMPLE_W-1:0]  sample,
    output logic                                  clipped
);

    // bank state
    logic [ahob_pkg::PHASE_W-1:0] phase_reg [ahob_pkg::NUM_HARMONICS];
    logic [ahob_pkg::GAIN_W-1:0]  gain_reg  [ahob_pkg::NUM_HARMONICS];
    logic [ahob_pkg::PHASE_W-1:0] base_step_reg;
    logic [ahob_pkg::SUM_W-1:0]   sum_reg;
    logic [ahob_pkg::RUN_W-1:0]   run_reg;
    logic [ahob_pkg::ENV_W-1:0]   env_reg;

    // harmonic pipe
    logic                           s1_valid_reg;
    logic                           s1_neg_reg;
    logic [ahob_pkg::SINE_MAG_W-1:0] s1_mag_reg;
    logic [ahob_pkg::EG_W-1:0]      s1_eg_reg;
    logic                           s2_valid_reg;
    logic                           s2_neg_reg;
    logic [ahob_pkg::PROD_W-1:0]    s2_prod_reg;
    logic [ahob_pkg::ACC_W-1:0]     acc_reg;

    // divider
    logic                           zero_reg;
    logic                           ovf_reg;
    logic                           neg_reg;
    logic [ahob_pkg::SUM_W-1:0]     rem_reg;
    logic [ahob_pkg::QUOT_W-1:0]    quot_reg;

    // result register
    logic                           out_valid_reg;
    logic [ahob_pkg::SAMPLE_W-1:0]  sample_reg;
    logic                           clipped_reg;

    logic [ahob_pkg::RUN_W-1:0]      cur_step;
    logic                            audible;
    logic [ahob_pkg::PHASE_W-1:0]    sel_phase;
    logic [ahob_pkg::GAIN_W-1:0]     sel_gain;
    logic [ahob_pkg::SINE_IDX_W-1:0] rom_idx;
    logic [1:0]                      quad;
    logic [ahob_pkg::SINE_K_W-1:0]   low_k;
    logic [ahob_pkg::SINE_K_W-1:0]   rom_k;
    logic [ahob_pkg::ACC_W-1:0]      prod_ext;
    logic [ahob_pkg::ACC_W-1:0]      acc_abs;
    logic [ahob_pkg::DIVD_W-1:0]     dividend;
    logic [ahob_pkg::DIVD_W-1:0]     div_limit;
    logic [ahob_pkg::SUM_W:0]        trial;
    logic [ahob_pkg::SUM_W:0]        trial_diff;
    logic                            trial_ge;
    logic [ahob_pkg::SAMPLE_W-1:0]   sample_next;
    logic                            clipped_next;

    // step of the current harmonic: base step at harmonic 0, running sum after that
    assign cur_step = (dp_cmd.harm == '0) ? ahob_pkg::RUN_W'(base_step_reg) : run_reg;
    assign audible  = (cur_step[ahob_pkg::RUN_W-1:ahob_pkg::PHASE_W-1] == '0);

    assign sel_phase = phase_reg[dp_cmd.harm];
    assign sel_gain  = gain_reg[dp_cmd.harm];

    // fold the table index onto the quarter wave
    assign rom_idx = sel_phase[ahob_pkg::PHASE_W-1 -: ahob_pkg::SINE_IDX_W];
    assign quad    = rom_idx[ahob_pkg::SINE_IDX_W-1 -: 2];
    assign low_k   = {1'b0, rom_idx[ahob_pkg::SINE_IDX_W-3:0]};
    assign rom_k   = quad[0] ? (ahob_pkg::SINE_K_W'(ahob_pkg::SINE_QTR) - low_k) : low_k;

    // phase accumulators, wrap modulo 2^32
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < ahob_pkg::NUM_HARMONICS; h++)
            begin
                phase_reg[h] <= '0;
            end
        end
        else if (dp_cmd.tick_issue)
        begin
            phase_reg[dp_cmd.harm] <= sel_phase + cur_step[ahob_pkg::PHASE_W-1:0];
        end
    end

    // gain store, base step and audible gain sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int h = 0; h < ahob_pkg::NUM_HARMONICS; h++)
            begin
                gain_reg[h] <= (h == 0) ? ahob_pkg::GAIN0_RESET : '0;
            end
            base_step_reg <= '0;
            sum_reg       <= ahob_pkg::SUM_RESET;
        end
        else
        begin
            if (dp_cmd.load_gain)
            begin
                gain_reg[harmonic_index] <= gain_value;
            end
            if (dp_cmd.load_step)
            begin
                base_step_reg <= note_step;
            end
            if (dp_cmd.sum_clear)
            begin
                sum_reg <= '0;
            end
            else if (dp_cmd.sum_issue && audible)
            begin
                sum_reg <= sum_reg + ahob_pkg::SUM_W'(sel_gain);
            end
        end
    end

    // running harmonic step and envelope capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.sum_issue || dp_cmd.tick_issue)
        begin
            run_reg <= cur_step + ahob_pkg::RUN_W'(base_step_reg);
        end
        if (dp_cmd.start_tick)
        begin
            env_reg <= envelope;
        end
    end

    // pipe stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= dp_cmd.tick_issue && audible;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // table lookup and envelope times gain, then times sine magnitude
    always_ff @(posedge clk)
    begin
        s1_mag_reg  <= ahob_pkg::SINE_ROM[rom_k];
        s1_neg_reg  <= quad[1];
        s1_eg_reg   <= env_reg * sel_gain;
        s2_prod_reg <= s1_eg_reg * s1_mag_reg;
        s2_neg_reg  <= s1_neg_reg;
    end

    // signed accumulation of harmonic terms
    assign prod_ext = {{(ahob_pkg::ACC_W - ahob_pkg::PROD_W){1'b0}}, s2_prod_reg};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start_tick)
        begin
            acc_reg <= '0;
        end
        else if (s2_valid_reg)
        begin
            acc_reg <= s2_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    // divider setup: magnitude, fraction shift and overflow check
    assign acc_abs   = acc_reg[ahob_pkg::ACC_W-1] ? ('0 - acc_reg) : acc_reg;
    assign dividend  = acc_abs[ahob_pkg::ACC_W-1:ahob_pkg::FRAC_W];
    assign div_limit = ahob_pkg::DIVD_W'({sum_reg, {ahob_pkg::QUOT_W{1'b0}}});

    // one restoring step per cycle
    assign trial      = {rem_reg, quot_reg[ahob_pkg::QUOT_W-1]};
    assign trial_diff = trial - {1'b0, sum_reg};
    assign trial_ge   = (trial >= {1'b0, sum_reg});

    always_ff @(posedge clk)
    begin
        if (dp_cmd.div_init)
        begin
            zero_reg <= (sum_reg == '0);
            ovf_reg  <= (dividend >= div_limit);
            neg_reg  <= acc_reg[ahob_pkg::ACC_W-1];
            rem_reg  <= dividend[ahob_pkg::QUOT_W +: ahob_pkg::SUM_W];
            quot_reg <= dividend[ahob_pkg::QUOT_W-1:0];
        end
        else if (dp_cmd.div_step)
        begin
            rem_reg  <= trial_ge ? trial_diff[ahob_pkg::SUM_W-1:0] : trial[ahob_pkg::SUM_W-1:0];
            quot_reg <= {quot_reg[ahob_pkg::QUOT_W-2:0], trial_ge};
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        sample_next  = '0;
        clipped_next = 1'b0;
        if (zero_reg)
        begin
            sample_next  = '0;
            clipped_next = 1'b0;
        end
        else if (ovf_reg)
        begin
            sample_next  = neg_reg ? ahob_pkg::SAMPLE_MIN : ahob_pkg::SAMPLE_MAX;
            clipped_next = 1'b1;
        end
        else if (neg_reg)
        begin
            if (quot_reg > ahob_pkg::NEG_LIMIT)
            begin
                sample_next  = ahob_pkg::SAMPLE_MIN;
                clipped_next = 1'b1;
            end
            else
            begin
                sample_next = ahob_pkg::SAMPLE_W'('0 - quot_reg);
            end
        end
        else
        begin
            if (quot_reg > ahob_pkg::POS_LIMIT)
            begin
                sample_next  = ahob_pkg::SAMPLE_MAX;
                clipped_next = 1'b1;
            end
            else
            begin
                sample_next = ahob_pkg::SAMPLE_W'(quot_reg);
            end
        end
    end

    // result register and its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            sample_reg  <= sample_next;
            clipped_reg <= clipped_next;
        end
    end

    assign dp_stat.out_free = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign sample           = $signed(sample_reg);
    assign clipped          = clipped_reg;

endmodule

// File: src/additive_harmonic_oscillator_bank_unit.sv
// additive_harmonic_oscillator_bank_unit: top level of the oscillator bank
// joins ahob_ctrl and ahob_datapath; uses ahob_pkg, ahob_cmd_if and ahob_res_if
//
// Usage:
//   cmd carries one item per transfer: func 0 is a sample tick (uses envelope),
//   func 1 a note-on (loads note_step), func 2 a gain write (harmonic_index,
//   gain_value); func 3 is taken and dropped. Only ticks give a result.
//   result carries sample (signed Q1.15, saturated) and clipped.
// Sequence:
//   a note-on or gain write is taken in ST_IDLE, then ST_SUM steps through the
//   harmonics to rebuild the audible gain sum.
//   a tick runs from its transfer through ST_TICK over the harmonics
//   (one per cycle on the shared lookup and multiplier pipe), ST_DRAIN to
//   drain that pipe, ST_DIV_INIT to set up the divider, ST_DIV for the
//   quotient at one bit per cycle, and ST_FINISH to load the result register
//   once it is free; result.valid rises once that load has happened.
// Reset clears phases and step, sets gain 0 to unity and the others to zero.
// A stalled receiver holds the result register; the block finishes the next
// tick and then waits until that register is free before taking more items.

module additive_harmonic_oscillator_bank_unit (
    input  logic           clk,
    input  logic           rst_n,
    ahob_cmd_if.sink       cmd,
    ahob_res_if.source     result
);

    ahob_pkg::dp_cmd_t     dp_cmd;
    ahob_pkg::dp_status_t  dp_stat;

    // sequencing
    ahob_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_func  (cmd.func),
        .in_ready (cmd.ready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    // arithmetic and state
    ahob_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .dp_cmd         (dp_cmd),
        .dp_stat        (dp_stat),
        .envelope       (cmd.envelope),
        .note_step      (cmd.note_step),
        .harmonic_index (cmd.harmonic_index),
        .gain_value     (cmd.gain_value),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .sample         (result.sample),
        .clipped        (result.clipped)
    );

endmodule
